/* design/priority_command_framer_core_assert.svh */
`ifndef PRIORITY_COMMAND_FRAMER_CORE_ASSERT_SVH
`define PRIORITY_COMMAND_FRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define PCF_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcf assertion failed");

// Next-cycle implication, checked while out of reset.
`define PCF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcf assertion failed");

`endif

/* design/pcf_pkg.sv */
`default_nettype none

package pcf_pkg;

    localparam int DATA_WORDS  = 4;
    localparam int FRAME_LEN   = 20;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [DATA_WORDS-1:0][31:0] t_words;
    typedef logic [4:0]                  t_byte_idx;

    // event commands
    localparam logic [2:0] EVT_TICK      = 3'd0;
    localparam logic [2:0] EVT_VEL_UPD   = 3'd1;
    localparam logic [2:0] EVT_DISP_UPD  = 3'd2;
    localparam logic [2:0] EVT_ARM_REQ   = 3'd3;
    localparam logic [2:0] EVT_SAFE_REQ  = 3'd4;
    localparam logic [2:0] EVT_LAND_REQ  = 3'd5;
    localparam logic [2:0] EVT_STOP_REQ  = 3'd6;

    // frame codes
    localparam logic [2:0] CODE_HEARTBEAT = 3'd0;
    localparam logic [2:0] CODE_ARM       = 3'd1;
    localparam logic [2:0] CODE_DISARM    = 3'd2;
    localparam logic [2:0] CODE_VELOCITY  = 3'd3;
    localparam logic [2:0] CODE_LAND      = 3'd5;
    localparam logic [2:0] CODE_EMERGENCY = 3'd6;
    localparam logic [2:0] CODE_DISPLAY   = 3'd7;

    // priorities
    localparam logic [2:0] PRIO_HEARTBEAT = 3'd0;
    localparam logic [2:0] PRIO_VELOCITY  = 3'd1;
    localparam logic [2:0] PRIO_DISPLAY   = 3'd2;
    localparam logic [2:0] PRIO_LAND      = 3'd3;
    localparam logic [2:0] PRIO_ARM       = 3'd4;
    localparam logic [2:0] PRIO_DISARM    = 3'd5;
    localparam logic [2:0] PRIO_EMERGENCY = 3'd6;

    // configuration register indexes
    localparam logic REG_SEND_PERIOD = 1'b0;
    localparam logic REG_STALE_AFTER = 1'b1;

    localparam logic [15:0] RST_SEND_PERIOD = 16'd100;
    localparam logic [15:0] RST_STALE_AFTER = 16'd200;

    // frame layout
    localparam logic [7:0] SYNC_BYTE    = 8'hA5;
    localparam logic [7:0] TRAILER_BYTE = 8'h5B;
    localparam t_byte_idx  IDX_SYNC     = 5'd0;
    localparam t_byte_idx  IDX_CODE     = 5'd1;
    localparam t_byte_idx  IDX_DATA0    = 5'd2;
    localparam t_byte_idx  IDX_CHECK    = 5'd18;
    localparam t_byte_idx  IDX_LAST     = 5'd19;

    typedef struct packed {
        logic [2:0] code;
        t_words     words;
    } t_frame;

    typedef struct packed {
        logic [2:0] code;
        logic [2:0] prio;
        logic       once;
        t_words     words;
    } t_active;

endpackage

`default_nettype wire

/* design/pcf_event_if.sv */
`default_nettype none

interface pcf_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;

    modport source (output valid, command, word0, word1, word2, word3, input ready);
    modport sink   (input valid, command, word0, word1, word2, word3, output ready);
endinterface

`default_nettype wire

/* design/pcf_byte_if.sv */
`default_nettype none

interface pcf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;

    modport source (output valid, tx_byte, frame_end, input ready);
    modport sink   (input valid, tx_byte, frame_end, output ready);
endinterface

`default_nettype wire

/* design/pcf_front.sv */
`default_nettype none

module pcf_front #(
    parameter int AGE_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [15:0]     i_cfg_data,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [2:0]      i_command,
    input  wire pcf_pkg::t_words i_words,
    output logic                 o_push,
    output pcf_pkg::t_frame      o_frame,
    input  wire logic            i_full
);
    import pcf_pkg::*;

    localparam int CW = (AGE_BITS > 16) ? AGE_BITS : 16;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    logic [15:0]         r_period;
    logic [15:0]         r_stale;
    t_active             r_act,        n_act;
    t_words              r_vel_words,  n_vel_words;
    t_words              r_disp_words, n_disp_words;
    logic [AGE_BITS-1:0] r_vel_age,    n_vel_age;
    logic [AGE_BITS-1:0] r_disp_age,   n_disp_age;
    logic                r_seen,       n_seen;
    logic [15:0]         r_pc,         n_pc;

    logic [AGE_BITS-1:0] vel_age_inc, disp_age_inc;
    logic [15:0]         pc_inc;
    logic                send, vel_fresh, disp_fresh, accept;
    t_active             t1, t2, t3, t4, after_send;

    function automatic t_active make_act(logic [2:0] code, logic [2:0] prio,
                                         logic once, t_words words);
        t_active a;
        a.code  = code;
        a.prio  = prio;
        a.once  = once;
        a.words = words;
        return a;
    endfunction

    function automatic t_active request_cmd(t_active cur, t_active req);
        return (req.prio >= cur.prio) ? req : cur;
    endfunction

    function automatic t_active base_cmd(t_active cur, logic vf, t_words vw);
        t_active a;
        if (vf) begin
            a = make_act(CODE_VELOCITY, PRIO_VELOCITY, 1'b0, vw);
        end else if (cur.code == CODE_VELOCITY && cur.once) begin
            a = make_act(CODE_HEARTBEAT, PRIO_HEARTBEAT, 1'b0, '0);
        end else begin
            // one zero-velocity word set, then heartbeat on the next send
            a = make_act(CODE_VELOCITY, PRIO_VELOCITY, 1'b1, '0);
        end
        return a;
    endfunction

    assign accept  = i_valid && o_ready;
    assign o_ready = !i_full;

    // tick path: ages, period and the refresh chain ahead of a send
    always_comb begin
        vel_age_inc  = (r_vel_age == AGE_MAX) ? r_vel_age : r_vel_age + 1'b1;
        disp_age_inc = (r_disp_age == AGE_MAX) ? r_disp_age : r_disp_age + 1'b1;
        pc_inc       = r_pc + 16'd1;
        send         = (pc_inc >= r_period);
        vel_fresh    = (CW'(vel_age_inc) < CW'(r_stale));
        disp_fresh   = r_seen && (CW'(disp_age_inc) < CW'(r_stale));

        t1 = disp_fresh ? request_cmd(r_act,
                 make_act(CODE_DISPLAY, PRIO_DISPLAY, 1'b0, r_disp_words)) : r_act;
        t2 = vel_fresh ? request_cmd(t1,
                 make_act(CODE_VELOCITY, PRIO_VELOCITY, 1'b0, r_vel_words)) : t1;
        t3 = (t2.code == CODE_VELOCITY && !vel_fresh) ?
                 base_cmd(t2, 1'b0, r_vel_words) : t2;
        t4 = (t3.code == CODE_DISPLAY && !disp_fresh) ?
                 make_act(CODE_HEARTBEAT, PRIO_HEARTBEAT, 1'b0, '0) : t3;
        after_send = t4.once ? base_cmd(t4, vel_fresh, r_vel_words) : t4;
    end

    assign o_frame = '{code: t4.code, words: t4.words};

    always_comb begin
        n_act        = r_act;
        n_vel_words  = r_vel_words;
        n_disp_words = r_disp_words;
        n_vel_age    = r_vel_age;
        n_disp_age   = r_disp_age;
        n_seen       = r_seen;
        n_pc         = r_pc;
        o_push       = 1'b0;
        if (accept) begin
            unique case (i_command)
                EVT_TICK: begin
                    n_vel_age  = vel_age_inc;
                    n_disp_age = disp_age_inc;
                    if (send) begin
                        n_pc   = '0;
                        o_push = 1'b1;
                        n_act  = after_send;
                    end else begin
                        n_pc = pc_inc;
                    end
                end
                EVT_VEL_UPD: begin
                    n_vel_words = i_words;
                    n_vel_age   = '0;
                    n_act = request_cmd(r_act,
                                make_act(CODE_VELOCITY, PRIO_VELOCITY, 1'b0, i_words));
                end
                EVT_DISP_UPD: begin
                    n_disp_words = i_words;
                    n_disp_age   = '0;
                    n_seen       = 1'b1;
                    n_act = request_cmd(r_act,
                                make_act(CODE_DISPLAY, PRIO_DISPLAY, 1'b0, i_words));
                end
                EVT_ARM_REQ: n_act = request_cmd(r_act,
                                make_act(CODE_ARM, PRIO_ARM, 1'b1, '0));
                EVT_SAFE_REQ: n_act = request_cmd(r_act,
                                make_act(CODE_DISARM, PRIO_DISARM, 1'b1, '0));
                EVT_LAND_REQ: n_act = request_cmd(r_act,
                                make_act(CODE_LAND, PRIO_LAND, 1'b1, '0));
                EVT_STOP_REQ: n_act = request_cmd(r_act,
                                make_act(CODE_EMERGENCY, PRIO_EMERGENCY, 1'b1, '0));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= RST_SEND_PERIOD;
            r_stale      <= RST_STALE_AFTER;
            r_act        <= make_act(CODE_HEARTBEAT, PRIO_HEARTBEAT, 1'b0, '0);
            r_vel_words  <= '0;
            r_disp_words <= '0;
            r_vel_age    <= '0;
            r_disp_age   <= '0;
            r_seen       <= 1'b0;
            r_pc         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SEND_PERIOD: r_period <= i_cfg_data;
                    REG_STALE_AFTER: r_stale  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_act        <= n_act;
            r_vel_words  <= n_vel_words;
            r_disp_words <= n_disp_words;
            r_vel_age    <= n_vel_age;
            r_disp_age   <= n_disp_age;
            r_seen       <= n_seen;
            r_pc         <= n_pc;
        end
    end

endmodule

`default_nettype wire

/* design/pcf_queue.sv */
`default_nettype none

module pcf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire pcf_pkg::t_frame i_data,
    output logic                 o_full,
    output logic                 o_valid,
    output pcf_pkg::t_frame      o_data,
    input  wire logic            i_pop
);
    import pcf_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_frame            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CNTW-1:0]   r_count;

    assign o_full  = (r_count == CNTW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNTW'(i_push) - CNTW'(i_pop);
        end
    end

endmodule

`default_nettype wire

/* design/pcf_back.sv */
`default_nettype none
`include "priority_command_framer_core_assert.svh"

module pcf_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire pcf_pkg::t_frame i_frame,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [7:0]           o_byte,
    output logic                 o_end
);
    import pcf_pkg::*;

    t_byte_idx  r_idx;
    logic [7:0] r_xor;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;

    logic                      adv;
    logic [3:0]                data_idx;
    logic [7:0]                cur_byte;
    logic [DATA_WORDS*32-1:0]  flat_words;

    // load the next byte whenever the output register is free or being taken
    assign adv        = i_valid && (!r_out_valid || i_ready);
    assign data_idx   = 4'(r_idx - IDX_DATA0);
    assign o_pop      = adv && (r_idx == IDX_LAST);
    assign flat_words = i_frame.words;

    always_comb begin
        case (r_idx)
            IDX_SYNC:  cur_byte = SYNC_BYTE;
            IDX_CODE:  cur_byte = {5'b0, i_frame.code};
            IDX_CHECK: cur_byte = r_xor;
            IDX_LAST:  cur_byte = TRAILER_BYTE;
            default:   cur_byte = flat_words[{data_idx, 3'b000} +: 8];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= cur_byte;
            r_out_end  <= (r_idx == IDX_LAST);
            r_xor      <= ((r_idx == IDX_SYNC) ? 8'h00 : r_xor) ^ cur_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= IDX_SYNC;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_idx       <= (r_idx == IDX_LAST) ? IDX_SYNC : r_idx + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_end   = r_out_end;

    `PCF_ASSERT_NEXT(a_wrap_after_trailer, i_clk, i_rst_n,
                     adv && (r_idx == IDX_LAST), r_idx == IDX_SYNC)
    `PCF_ASSERT_NOW(a_end_is_trailer, i_clk, i_rst_n,
                    r_out_valid && r_out_end, r_out_byte == TRAILER_BYTE)
    `PCF_ASSERT_NEXT(a_frame_opens_sync, i_clk, i_rst_n,
                     adv && (r_idx == IDX_SYNC), (r_out_byte == SYNC_BYTE) && !r_out_end)

endmodule

`default_nettype wire

/* design/priority_command_framer_core.sv */
`default_nettype none
// Channel   Port     Dir   Word
// events    i_evt    in    command, word0..word3
// bytes     o_tx     out   tx_byte, frame_end
//
// Events are taken one per cycle while i_evt.ready is high; a tick that ends a send period queues one frame.
// A frame leaves as 20 bytes at one byte per cycle while o_tx.ready allows, paced by the byte serializer.
// The frame queue holds two frames; i_evt.ready drops only while it is full.
// Reset is synchronous; config takes effect on the cycle after the write.

module priority_command_framer_core #(
    parameter int AGE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    pcf_event_if.sink        i_evt,
    pcf_byte_if.source       o_tx
);
    import pcf_pkg::*;

    t_words evt_words;
    t_frame push_frame;
    t_frame head_frame;
    logic   push, full, head_valid, pop;

    assign evt_words = {i_evt.word3, i_evt.word2, i_evt.word1, i_evt.word0};

    pcf_front #(
        .AGE_BITS (AGE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_evt.valid),
        .o_ready    (i_evt.ready),
        .i_command  (i_evt.command),
        .i_words    (evt_words),
        .o_push     (push),
        .o_frame    (push_frame),
        .i_full     (full)
    );

    pcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_frame),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_frame),
        .i_pop   (pop)
    );

    pcf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_frame (head_frame),
        .o_pop   (pop),
        .o_valid (o_tx.valid),
        .i_ready (o_tx.ready),
        .o_byte  (o_tx.tx_byte),
        .o_end   (o_tx.frame_end)
    );

endmodule

`default_nettype wire
